// ===== sv/ami_pkg.sv =====
// Shared types and constants for the affine matrix inverse block.
package ami_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int LANES         = 6;
    localparam int QBITS         = 33;
    localparam int CNT_W         = $clog2(QBITS);
    localparam int QDEPTH        = 2;
    localparam int THR_RESET     = 512;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FIN
    } t_state;

    typedef struct packed {
        logic [63:0]            den;
        logic                   inv;
        logic [LANES-1:0][63:0] mag;
        logic [LANES-1:0]       neg;
    } t_job;

endpackage

// ===== sv/ami_front.sv =====
// Front: products, determinant, threshold test and job build.
module ami_front import ami_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [191:0] i_data,
    input  logic [31:0]  i_thr,
    output logic         o_push,
    input  logic         i_space,
    output t_job         o_job
);

    logic signed [31:0] w_a, w_b, w_c, w_d, w_tx, w_ty;
    logic signed [63:0] r_p_ad, r_p_bc, r_p_cty, r_p_dtx, r_p_btx, r_p_aty;
    logic signed [31:0] r_a, r_b, r_c, r_d;
    logic               r_v1;
    logic               w_adv;
    logic signed [64:0] w_det_s, w_tx_s, w_ty_s;
    logic [64:0]        w_det_m, w_tx_m, w_ty_m;

    assign w_a  = i_data[31:0];
    assign w_b  = i_data[63:32];
    assign w_c  = i_data[95:64];
    assign w_d  = i_data[127:96];
    assign w_tx = i_data[159:128];
    assign w_ty = i_data[191:160];

    assign w_adv   = !r_v1 || i_space;
    assign o_ready = w_adv;
    assign o_push  = r_v1 && i_space;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && i_valid) begin
            r_p_ad  <= w_a * w_d;
            r_p_bc  <= w_b * w_c;
            r_p_cty <= w_c * w_ty;
            r_p_dtx <= w_d * w_tx;
            r_p_btx <= w_b * w_tx;
            r_p_aty <= w_a * w_ty;
            r_a     <= w_a;
            r_b     <= w_b;
            r_c     <= w_c;
            r_d     <= w_d;
        end
    end

    always_comb begin
        w_det_s = 65'(r_p_ad) - 65'(r_p_bc);
        w_tx_s  = 65'(r_p_cty) - 65'(r_p_dtx);
        w_ty_s  = 65'(r_p_btx) - 65'(r_p_aty);
        w_det_m = w_det_s[64] ? 65'(-w_det_s) : 65'(w_det_s);
        w_tx_m  = w_tx_s[64] ? 65'(-w_tx_s) : 65'(w_tx_s);
        w_ty_m  = w_ty_s[64] ? 65'(-w_ty_s) : 65'(w_ty_s);
        o_job.den    = w_det_m[63:0];
        o_job.inv    = !w_det_s[64] && (w_det_m[63:0] > 64'(i_thr));
        o_job.mag[0] = r_d[31] ? 64'(-65'(r_d)) : 64'(r_d);
        o_job.mag[1] = r_b[31] ? 64'(-65'(r_b)) : 64'(r_b);
        o_job.mag[2] = r_c[31] ? 64'(-65'(r_c)) : 64'(r_c);
        o_job.mag[3] = r_a[31] ? 64'(-65'(r_a)) : 64'(r_a);
        o_job.mag[4] = w_tx_m[63:0];
        o_job.mag[5] = w_ty_m[63:0];
        o_job.neg[0] = r_d[31];
        o_job.neg[1] = !r_b[31] && (r_b != 32'sd0);
        o_job.neg[2] = !r_c[31] && (r_c != 32'sd0);
        o_job.neg[3] = r_a[31];
        o_job.neg[4] = w_tx_s[64];
        o_job.neg[5] = w_ty_s[64];
    end

endmodule

// ===== sv/ami_fifo.sv =====
// Short job queue between front and back.
module ami_fifo import ami_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_space,
    output logic o_valid,
    input  logic i_pop,
    output t_job o_job
);

    localparam int PW = $clog2(QDEPTH);

    t_job               r_mem [QDEPTH];
    logic [PW-1:0]      r_wp, r_rp;
    logic [PW:0]        r_cnt;
    logic               w_pop;

    assign o_space = r_cnt != (PW+1)'(QDEPTH);
    assign o_valid = r_cnt != '0;
    assign o_job   = r_mem[r_rp];
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= PW'(r_wp + 1'b1);
            if (w_pop)  r_rp <= PW'(r_rp + 1'b1);
            r_cnt <= (PW+1)'(r_cnt + (PW+1)'(i_push) - (PW+1)'(w_pop));
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> o_space) else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == '0 |-> !o_valid) else $error("queue valid while empty");
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !w_pop && r_cnt == '0) |=> r_cnt == (PW+1)'(1))
        else $error("queue count lost a word");

endmodule

// ===== sv/ami_div_lane.sv =====
// One restoring divider lane with round-to-nearest and saturation.
module ami_div_lane import ami_pkg::*; #(
    parameter int SH = 32
) (
    input  logic        i_clk,
    input  logic        i_load,
    input  logic        i_step,
    input  logic [63:0] i_mag,
    input  logic        i_neg,
    input  logic [63:0] i_den,
    output logic [31:0] o_val,
    output logic        o_sat
);

    localparam int NW = 64 + SH;
    localparam int CW = (NW > QBITS + 64) ? NW : QBITS + 64;

    logic [NW-1:0]    w_num;
    logic             w_ovf;
    logic [63:0]      r_rem, r_den;
    logic [QBITS-1:0] r_lo, r_q;
    logic             r_ovf, r_neg;
    logic [64:0]      w_t;
    logic             w_ge;
    logic             w_rnd;
    logic [QBITS:0]   w_qr, w_lim;
    logic [31:0]      w_mag;

    assign w_num = NW'(i_mag) << SH;
    assign w_ovf = CW'(w_num) >= (CW'(i_den) << QBITS);
    assign w_t   = {r_rem, r_lo[QBITS-1]};
    assign w_ge  = w_t >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rem <= 64'(w_num >> QBITS);
            r_lo  <= w_num[QBITS-1:0];
            r_q   <= '0;
            r_ovf <= w_ovf;
            r_neg <= i_neg;
            r_den <= i_den;
        end else if (i_step) begin
            r_rem <= w_ge ? 64'(w_t - {1'b0, r_den}) : 64'(w_t);
            r_q   <= {r_q[QBITS-2:0], w_ge};
            r_lo  <= {r_lo[QBITS-2:0], 1'b0};
        end
    end

    always_comb begin
        w_rnd = {r_rem, 1'b0} >= {1'b0, r_den};
        w_qr  = {1'b0, r_q} + (QBITS+1)'(w_rnd);
        w_lim = r_neg ? (QBITS+1)'(33'h080000000) : (QBITS+1)'(33'h07FFFFFFF);
        o_sat = r_ovf || (w_qr > w_lim);
        w_mag = o_sat ? w_lim[31:0] : w_qr[31:0];
        o_val = r_neg ? 32'(-w_mag) : w_mag;
    end

endmodule

// ===== sv/ami_back.sv =====
// Back: divider lanes, sequencer and output register.
module ami_back import ami_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_pop,
    input  t_job         i_job,
    output logic         o_tvalid,
    input  logic         i_tready,
    output logic [191:0] o_tdata,
    output logic [1:0]   o_tuser
);

    t_state                  r_state, n_state;
    logic [CNT_W-1:0]        r_cnt;
    logic                    r_inv;
    logic                    w_load, w_step, w_oload;
    logic [LANES-1:0][31:0]  w_val;
    logic [LANES-1:0]        w_sat;
    logic [191:0]            r_odata;
    logic                    r_oinv, r_osat, r_ov;

    for (genvar k = 0; k < LANES; k++) begin : g_lane
        localparam int SH = (k < 4) ? 2 * FRAC_BITS : FRAC_BITS;
        ami_div_lane #(.SH(SH)) u_lane (
            .i_clk  (i_clk),
            .i_load (w_load),
            .i_step (w_step),
            .i_mag  (i_job.mag[k]),
            .i_neg  (i_job.neg[k]),
            .i_den  (i_job.den),
            .o_val  (w_val[k]),
            .o_sat  (w_sat[k])
        );
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_RUN;
            end
            S_RUN: begin
                if (r_cnt == CNT_W'(QBITS - 1)) n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_ov || i_tready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_load  = (r_state == S_IDLE) && i_valid;
        w_step  = (r_state == S_RUN);
        w_oload = (r_state == S_FIN) && (!r_ov || i_tready);
    end

    assign o_pop = w_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load)      r_cnt <= '0;
            else if (w_step) r_cnt <= CNT_W'(r_cnt + 1'b1);
            if (w_oload)       r_ov <= 1'b1;
            else if (i_tready) r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) r_inv <= i_job.inv;
        if (w_oload) begin
            r_odata <= r_inv ? w_val : '0;
            r_oinv  <= r_inv;
            r_osat  <= r_inv && (|w_sat);
        end
    end

    assign o_tvalid = r_ov;
    assign o_tdata  = r_odata;
    assign o_tuser  = {r_osat, r_oinv};

    a_zero_when_singular: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !r_oinv) |-> (r_odata == '0 && !r_osat))
        else $error("non-invertible result not cleared");
    a_idle_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && !i_valid) |=> r_state == S_IDLE)
        else $error("sequencer left idle without a job");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RUN |-> r_cnt < CNT_W'(QBITS))
        else $error("divide step count out of range");

endmodule

// ===== sv/affine_matrix_invert.sv =====
// Top level of the 2D affine matrix inverse in signed fixed point.
// One matrix word in, one inverse word out. The front stage registers the six products,
// then forms the determinant and threshold test as it queues a job (two
// deep); the back runs six restoring divider lanes in parallel, one quotient bit per
// cycle, in the steps load, 33 divide steps and round/saturate, and takes a new job
// only from idle, while the queue lets the front accept further words meanwhile.
module affine_matrix_invert import ami_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [31:0]  i_cfg_wdata,   // det_threshold
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [191:0] s_axis_tdata,  // m_a, m_b, m_c, m_d, m_tx, m_ty
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [191:0] m_axis_tdata,  // r_a, r_b, r_c, r_d, r_tx, r_ty
    output logic [1:0]   m_axis_tuser   // invertible, saturated
);

    logic [31:0] r_thr;
    logic        w_push, w_space, w_qvalid, w_pop;
    t_job        w_job_in, w_job_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= 32'(THR_RESET);
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    ami_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .i_thr   (r_thr),
        .o_push  (w_push),
        .i_space (w_space),
        .o_job   (w_job_in)
    );

    ami_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .o_space (w_space),
        .o_valid (w_qvalid),
        .i_pop   (w_pop),
        .o_job   (w_job_out)
    );

    ami_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_qvalid),
        .o_pop    (w_pop),
        .i_job    (w_job_out),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser)
    );

endmodule
